// File: rtl/idiv_pkg.sv
// Shared types and constants for the 64-bit signed/unsigned integer divider.
package idiv_pkg;

    localparam int unsigned FieldWidth       = 64;
    localparam int unsigned DataWidthDefault = 64;

    typedef enum logic {
        OP_UNSIGNED = 1'b0,
        OP_SIGNED   = 1'b1
    } t_opcode;

    typedef struct packed {
        logic                  opcode;
        logic [FieldWidth-1:0] dividend;
        logic [FieldWidth-1:0] divisor;
    } t_in_item;

    typedef struct packed {
        logic [FieldWidth-1:0] quotient;
        logic [FieldWidth-1:0] remainder;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_NEG,
        S_DIV,
        S_FIX
    } t_state;

endpackage

// File: rtl/idiv_core.sv
// Radix-2 restoring division unit: one quotient bit per cycle, MSB first.
module idiv_core #(
    parameter int unsigned DATA_WIDTH = idiv_pkg::DataWidthDefault
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [DATA_WIDTH-1:0]     i_n,
    input  logic [DATA_WIDTH-1:0]     i_d,
    output idiv_pkg::t_core_stat      o_stat,
    output logic [DATA_WIDTH-1:0]     o_quo,
    output logic [DATA_WIDTH-1:0]     o_rem
);

    localparam int unsigned CntW = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] r_rem, n_rem;
    // holds the dividend bits still to enter; quotient bits shift in at the bottom
    logic [DATA_WIDTH-1:0] r_quo, n_quo;
    logic [DATA_WIDTH-1:0] r_d;
    logic [CntW-1:0]       r_cnt;
    logic                  r_run;
    logic                  r_done;

    logic [DATA_WIDTH-1:0] shifted;
    logic [DATA_WIDTH-1:0] diff;
    logic                  carry;
    logic                  take;

    always_comb begin
        carry   = r_rem[DATA_WIDTH-1];
        shifted = {r_rem[DATA_WIDTH-2:0], r_quo[DATA_WIDTH-1]};
        diff    = shifted - r_d;
        // the bit shifted out of the remainder makes it exceed any divisor
        take    = carry | (shifted >= r_d);
        n_rem   = take ? diff : shifted;
        n_quo   = {r_quo[DATA_WIDTH-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CntW'(DATA_WIDTH - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_n;
            r_d   <= i_d;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_stat.busy = r_run;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
    assign o_rem       = r_rem;

endmodule

// File: rtl/int64_divider_signed_unsigned.sv
// Top level of the signed/unsigned integer divider with sign handling and output register.
// Path from accepted input to output valid: the operand-magnitude state S_NEG,
//   DATA_WIDTH restoring steps in S_DIV, the done handoff, and the sign fix in S_FIX.
// One transaction at a time: a new input is taken only in S_IDLE, after the result is loaded;
//   the divide loop retires one quotient bit per cycle, and S_FIX holds while the output stalls;
//   a new input is taken while a finished result waits in the output register.
// Reset: synchronous active-low i_rst_n clears the sequencer and the output valid flag.
module int64_divider_signed_unsigned #(
    parameter int unsigned DATA_WIDTH = idiv_pkg::DataWidthDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  idiv_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output idiv_pkg::t_out_item  o_out
);

    idiv_pkg::t_state r_state, n_state;

    logic                  r_op;
    logic [DATA_WIDTH-1:0] r_n;
    logic [DATA_WIDTH-1:0] r_d;
    logic                  r_nneg;
    logic                  r_dneg;
    logic                  r_dz;

    logic                  r_out_valid;
    idiv_pkg::t_out_item   r_out;

    logic                  in_accept;
    logic                  start;
    logic                  out_load;
    logic                  nneg;
    logic                  dneg;
    logic [DATA_WIDTH-1:0] dvd_mag;
    logic [DATA_WIDTH-1:0] dvs_mag;
    logic [DATA_WIDTH-1:0] q_fix;
    logic [DATA_WIDTH-1:0] rem_fix;

    idiv_pkg::t_core_stat  core_stat;
    logic [DATA_WIDTH-1:0] core_quo;
    logic [DATA_WIDTH-1:0] core_rem;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != idiv_pkg::S_IDLE);

    // magnitudes of the captured operands
    always_comb begin
        nneg    = (r_op == idiv_pkg::OP_SIGNED) && r_n[DATA_WIDTH-1];
        dneg    = (r_op == idiv_pkg::OP_SIGNED) && r_d[DATA_WIDTH-1];
        dvd_mag = nneg ? ({DATA_WIDTH{1'b0}} - r_n) : r_n;
        dvs_mag = dneg ? ({DATA_WIDTH{1'b0}} - r_d) : r_d;
    end

    // sign fix; a zero divisor forces both results to zero
    always_comb begin
        if (r_dz) begin
            q_fix   = '0;
            rem_fix = '0;
        end else begin
            q_fix   = (r_nneg != r_dneg) ? ({DATA_WIDTH{1'b0}} - core_quo) : core_quo;
            rem_fix = r_nneg ? ({DATA_WIDTH{1'b0}} - core_rem) : core_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= idiv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        start    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            idiv_pkg::S_IDLE: begin
                if (in_accept) n_state = idiv_pkg::S_NEG;
            end
            idiv_pkg::S_NEG: begin
                start   = 1'b1;
                n_state = idiv_pkg::S_DIV;
            end
            idiv_pkg::S_DIV: begin
                if (core_stat.done) n_state = idiv_pkg::S_FIX;
            end
            idiv_pkg::S_FIX: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = idiv_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = idiv_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op <= i_in.opcode;
            r_n  <= i_in.dividend[DATA_WIDTH-1:0];
            r_d  <= i_in.divisor[DATA_WIDTH-1:0];
        end
        if (start) begin
            r_nneg <= nneg;
            r_dneg <= dneg;
            r_dz   <= (r_d == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.quotient  <= idiv_pkg::FieldWidth'(q_fix);
            r_out.remainder <= idiv_pkg::FieldWidth'(rem_fix);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    idiv_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_n     (dvd_mag),
        .i_d     (dvs_mag),
        .o_stat  (core_stat),
        .o_quo   (core_quo),
        .o_rem   (core_rem)
    );

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_stat.done |-> (r_state == idiv_pkg::S_DIV))
        else $error("divide unit finished outside the divide state");

    a_busy_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_stat.busy |-> (r_state == idiv_pkg::S_DIV))
        else $error("divide unit running outside the divide state");

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> core_stat.busy)
        else $error("divide unit did not start");

    a_fix_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == idiv_pkg::S_FIX && r_out_valid && i_out_stall)
            |=> (r_state == idiv_pkg::S_FIX && $stable(r_out)))
        else $error("result overwrote a stalled output transaction");

endmodule
